// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/afa_pkg.sv
// Package for the fault address calculator: item structs, codes and decode masks.
// Used by the RAM, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package afa_pkg;

	localparam int RfDepth = 16;
	localparam int RfWidth = 32;
	localparam int RfAddrW = $clog2(RfDepth);

	localparam logic FuncWrite   = 1'b0;
	localparam logic FuncCompute = 1'b1;

	localparam logic [15:0] ThMaskPc   = 16'hF800;
	localparam logic [15:0] ThLdrPc    = 16'h4800;
	localparam logic [15:0] ThMaskReg  = 16'hF200;
	localparam logic [15:0] ThRegWord  = 16'h5000;
	localparam logic [15:0] ThRegHalf  = 16'h5200;
	localparam logic [15:0] ThMaskImm  = 16'hE000;
	localparam logic [15:0] ThImm      = 16'h6000;
	localparam logic [15:0] ThMaskHi   = 16'hF000;
	localparam logic [15:0] ThHalfImm  = 16'h8000;
	localparam logic [15:0] ThSpRel    = 16'h9000;
	localparam logic [15:0] ThMaskPush = 16'hF700;
	localparam logic [15:0] ThPushPop  = 16'hB500;
	localparam logic [15:0] ThBlock    = 16'hC000;

	localparam logic [31:0] ArmSwpMask  = 32'h0FB00FF0;
	localparam logic [31:0] ArmSwp      = 32'h01000090;
	localparam logic [31:0] ArmSdtMask  = 32'h0C000000;
	localparam logic [31:0] ArmSdt      = 32'h04000000;
	localparam logic [31:0] ArmHalfMask = 32'h0E400F90;
	localparam logic [31:0] ArmHalfReg  = 32'h00000090;
	localparam logic [31:0] ArmHalfImm  = 32'h00400090;
	localparam logic [31:0] ArmBlkMask  = 32'h0E000000;
	localparam logic [31:0] ArmBlk      = 32'h08000000;

	localparam logic [7:0] ShiftNone = 8'h0B;

	localparam logic [1:0] ShLsl = 2'd0;
	localparam logic [1:0] ShLsr = 2'd1;
	localparam logic [1:0] ShAsr = 2'd2;
	localparam logic [1:0] ShRor = 2'd3;

	typedef struct packed {
		logic        func;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic [31:0] opcode;
		logic        thumb;
	} afa_in_t;

	typedef struct packed {
		logic [31:0] address;
		logic        recognized;
	} afa_out_t;

endpackage

`default_nettype wire

// File: sv/arm_fault_address_calc.sv
// Top level of the ARM/Thumb load/store address calculator.
// Depends on afa_pkg and instantiates two copies of afa_ram.
`timescale 1ns / 1ps
`default_nettype none

// A write item loads one register in the cycle it is accepted and gives no result.
// A compute item reads its base and offset registers from two register-file memories,
// and the low byte of its shift register from a small register array, at the edge it
// is accepted. It is decoded, shifted and added combinationally from those registered
// values and is loaded into the output register once that register is free or being
// emptied, so its result passes the registered memory read and then the output
// register before it can be taken. While the output register is free or being
// emptied the block accepts one item every cycle. Registers read as zero until first
// written after reset.
module arm_fault_address_calc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  afa_pkg::afa_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output afa_pkg::afa_out_t out_item
);
	import afa_pkg::*;

	function automatic logic [RfAddrW-1:0] thumb_base_idx(input logic [15:0] op);
		logic [RfAddrW-1:0] idx;
		idx = '0;
		if ((op & ThMaskPc) == ThLdrPc) begin
			idx = RfAddrW'(15);
		end else if ((op & ThMaskReg) == ThRegWord || (op & ThMaskReg) == ThRegHalf ||
				(op & ThMaskImm) == ThImm || (op & ThMaskHi) == ThHalfImm) begin
			idx = RfAddrW'(op[5:3]);
		end else if ((op & ThMaskHi) == ThSpRel || (op & ThMaskPush) == ThPushPop) begin
			idx = RfAddrW'(13);
		end else begin
			idx = RfAddrW'(op[10:8]);
		end
		return idx;
	endfunction

	logic                    accept;
	logic                    wr_en;
	logic                    rd_en;
	logic                    out_free;
	logic [RfAddrW-1:0]      addr_a;
	logic [RfAddrW-1:0]      addr_b;
	logic [RfAddrW-1:0]      addr_c;
	logic [RfWidth-1:0]      rdata_a;
	logic [RfWidth-1:0]      rdata_b;
	logic [RfDepth-1:0]      vld_q;
	logic [RfDepth-1:0][7:0] rs_lo_q;
	logic                    v_s1;
	logic [31:0]             op_s1;
	logic                    thumb_s1;
	logic                    va_s1;
	logic                    vb_s1;
	logic [7:0]              rs_s1;
	logic [31:0]             ra;
	logic [31:0]             rb;
	logic [7:0]              sb;
	logic [7:0]              amt;
	logic [63:0]             rot;
	logic [31:0]             shifted;
	logic [31:0]             off;
	logic [15:0]             op16;
	logic [31:0]             imm5;
	afa_out_t                calc;
	logic                    out_valid_q;
	afa_out_t                out_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || out_free;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && in_item.func == FuncWrite;
	assign rd_en    = accept && in_item.func == FuncCompute;

	assign addr_a = in_item.thumb ? thumb_base_idx(in_item.opcode[15:0]) : in_item.opcode[19:16];
	assign addr_b = in_item.thumb ? RfAddrW'(in_item.opcode[8:6]) : in_item.opcode[3:0];
	assign addr_c = in_item.opcode[11:8];

	afa_ram #(.Width(RfWidth), .Depth(RfDepth)) u_bank_a (
		.clk(clk), .we(wr_en), .waddr(in_item.reg_index), .wdata(in_item.reg_value),
		.re(rd_en), .raddr(addr_a), .rdata(rdata_a)
	);

	afa_ram #(.Width(RfWidth), .Depth(RfDepth)) u_bank_b (
		.clk(clk), .we(wr_en), .waddr(in_item.reg_index), .wdata(in_item.reg_value),
		.re(rd_en), .raddr(addr_b), .rdata(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rs_lo_q     <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[in_item.reg_index]   <= 1'b1;
				rs_lo_q[in_item.reg_index] <= in_item.reg_value[7:0];
			end
			if (rd_en) begin
				v_s1 <= 1'b1;
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_s1    <= in_item.opcode;
			thumb_s1 <= in_item.thumb;
			va_s1    <= vld_q[addr_a];
			vb_s1    <= vld_q[addr_b];
			rs_s1    <= rs_lo_q[addr_c];
		end
		if (v_s1 && out_free) begin
			out_q <= calc;
		end
	end

	assign ra = va_s1 ? rdata_a : '0;
	assign rb = vb_s1 ? rdata_b : '0;

	always_comb begin
		sb      = op_s1[11:4];
		amt     = sb[0] ? rs_s1 : {3'b000, sb[7:3]};
		rot     = {rb, rb} >> amt[4:0];
		shifted = rb;
		case (sb[2:1])
			ShLsl: shifted = (amt[7:5] != 3'd0) ? '0 : rb << amt[4:0];
			ShLsr: shifted = (amt[7:5] != 3'd0) ? '0 : rb >> amt[4:0];
			ShAsr: shifted = (amt[7:5] != 3'd0) ? {32{rb[31]}} :
					32'($signed(rb) >>> amt[4:0]);
			ShRor: shifted = rot[31:0];
			default: shifted = rb;
		endcase
		if (sb == ShiftNone) begin
			shifted = rb;
		end
	end

	always_comb begin
		op16 = op_s1[15:0];
		imm5 = {27'd0, op16[10:6]};
		off  = '0;
		calc = '0;
		if (thumb_s1) begin
			calc.recognized = 1'b1;
			if ((op16 & ThMaskPc) == ThLdrPc) begin
				calc.address = (ra & ~32'd3) + {22'd0, op16[7:0], 2'b00};
			end else if ((op16 & ThMaskReg) == ThRegWord || (op16 & ThMaskReg) == ThRegHalf) begin
				calc.address = ra + rb;
			end else if ((op16 & ThMaskImm) == ThImm) begin
				calc.address = ra + (op16[12] ? imm5 : {imm5[29:0], 2'b00});
			end else if ((op16 & ThMaskHi) == ThHalfImm) begin
				calc.address = ra + {imm5[30:0], 1'b0};
			end else if ((op16 & ThMaskHi) == ThSpRel) begin
				calc.address = ra + {22'd0, op16[7:0], 2'b00};
			end else if ((op16 & ThMaskPush) == ThPushPop || (op16 & ThMaskHi) == ThBlock) begin
				calc.address = ra;
			end else begin
				calc.recognized = 1'b0;
			end
		end else begin
			calc.recognized = 1'b1;
			if ((op_s1 & ArmSwpMask) == ArmSwp) begin
				calc.address = ra;
			end else if ((op_s1 & ArmSdtMask) == ArmSdt) begin
				off = op_s1[25] ? shifted : {20'd0, op_s1[11:0]};
				calc.address = !op_s1[24] ? ra : (op_s1[23] ? ra + off : ra - off);
			end else if ((op_s1 & ArmHalfMask) == ArmHalfReg && op_s1[6:5] != 2'b00) begin
				off = rb;
				calc.address = !op_s1[24] ? ra : (op_s1[23] ? ra + off : ra - off);
			end else if ((op_s1 & ArmHalfMask) == ArmHalfImm && op_s1[6:5] != 2'b00) begin
				off = {24'd0, op_s1[11:8], op_s1[3:0]};
				calc.address = !op_s1[24] ? ra : (op_s1[23] ? ra + off : ra - off);
			end else if ((op_s1 & ArmBlkMask) == ArmBlk) begin
				calc.address = ra;
			end else begin
				calc.recognized = 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// File: sv/afa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on afa_pkg for its default sizes.
`timescale 1ns / 1ps
`default_nettype none

module afa_ram #(
	parameter int Width = afa_pkg::RfWidth,
	parameter int Depth = afa_pkg::RfDepth
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/afa_checker.sv
// Port-level checker for arm_fault_address_calc, attached by the bind at the end.
// Depends on afa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module afa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input afa_pkg::afa_in_t  in_item,
	input logic              out_valid,
	input logic              out_ready,
	input afa_pkg::afa_out_t out_item
);
	import afa_pkg::*;

	logic in_compute;
	logic out_stall;
	logic out_unknown;

	assign in_compute  = in_valid && in_ready && in_item.func == FuncCompute;
	assign out_stall   = out_valid && !out_ready;
	assign out_unknown = out_valid && !out_item.recognized;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_item))
	`ASSERT_IMPLIES(a_stall_only_on_full_out, clk, arst_n, !in_ready, out_stall)
	`ASSERT_IMPLIES(a_result_from_compute, clk, arst_n, $rose(out_valid), $past(in_compute, 2))
	`ASSERT_IMPLIES(a_unknown_gives_zero, clk, arst_n, out_unknown, out_item.address == 32'd0)

endmodule

bind arm_fault_address_calc afa_checker u_afa_checker (.*);

`default_nettype wire
